[rtl/bpr_pkg.sv]
package bpr_pkg;

  localparam int unsigned MAX_CHANNEL_BITS_DEF = 16;

  localparam int unsigned MASK_W  = 32;
  localparam int unsigned SHIFT_W = 5;
  localparam int unsigned WIDTH_W = 6;
  localparam int unsigned COMP_W  = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PIXB_W  = 3;

  // scaling datapath for fields narrower than a byte
  localparam int unsigned NARROW_W   = 7;   // widest narrow field
  localparam int unsigned LOWW_W     = 3;   // width code of a narrow field
  localparam int unsigned X_W        = 15;  // v*255 + max/2
  localparam int unsigned RECIP_W    = 17;
  localparam int unsigned RECIP_FRAC = 16;
  localparam int unsigned PROD_W     = 24;

  // pipeline stages
  localparam int unsigned NUM_STAGES  = 5;
  localparam int unsigned STG_LAYOUT  = 0;
  localparam int unsigned STG_EXTRACT = 1;
  localparam int unsigned STG_PREP    = 2;
  localparam int unsigned STG_MUL     = 3;
  localparam int unsigned STG_OUT     = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_RED    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_GREEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_BLUE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES = 2'd3;

  localparam logic [MASK_W-1:0] MASK_RED_RST   = 32'h00ff_0000;
  localparam logic [MASK_W-1:0] MASK_GREEN_RST = 32'h0000_ff00;
  localparam logic [MASK_W-1:0] MASK_BLUE_RST  = 32'h0000_00ff;
  localparam logic [PIXB_W-1:0] PIXB_RST       = 3'd3;
  localparam logic [PIXB_W-1:0] PIXB_FOUR      = 3'd4;

  typedef struct packed {
    logic [SHIFT_W-1:0] shift;
    logic [WIDTH_W-1:0] width;
    logic               contig;  // nonzero and one run of ones
  } mask_info_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] load;
  } pipe_ctl_t;

  // floor(2^16 / (2^w - 1)); one correction step after the multiply gives the exact quotient
  function automatic logic [RECIP_W-1:0] recip_of(input logic [LOWW_W-1:0] w);
    logic [RECIP_W-1:0] r;
    unique case (w)
      3'd1:    r = 17'd65536;
      3'd2:    r = 17'd21845;
      3'd3:    r = 17'd9362;
      3'd4:    r = 17'd4369;
      3'd5:    r = 17'd2114;
      3'd6:    r = 17'd1040;
      3'd7:    r = 17'd516;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [NARROW_W-1:0] field_max(input logic [LOWW_W-1:0] w);
    logic [NARROW_W:0] one_up;
    one_up = (NARROW_W+1)'(1) << w;
    return NARROW_W'(one_up - (NARROW_W+1)'(1));
  endfunction

endpackage

[rtl/bpr_mask_info.sv]
module bpr_mask_info (
  input  logic [bpr_pkg::MASK_W-1:0] mask_i,
  output bpr_pkg::mask_info_t        info_o
);
  import bpr_pkg::*;

  localparam int unsigned NIBS = MASK_W / 4;

  logic [MASK_W-1:0]  lowbit;
  logic [MASK_W-1:0]  upper;
  logic [SHIFT_W-1:0] shift;
  logic [WIDTH_W-1:0] width;
  logic [2:0]         nib_cnt [NIBS];

  always_comb begin
    lowbit = mask_i & (~mask_i + MASK_W'(1));
    upper  = mask_i + lowbit;

    shift = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (lowbit[i]) shift = shift | SHIFT_W'(i);
    end

    for (int k = 0; k < NIBS; k++) begin
      nib_cnt[k] = 3'(mask_i[4*k]) + 3'(mask_i[4*k+1]) +
                   3'(mask_i[4*k+2]) + 3'(mask_i[4*k+3]);
    end
    width = '0;
    for (int k = 0; k < NIBS; k++) begin
      width = width + WIDTH_W'(nib_cnt[k]);
    end

    info_o.shift  = shift;
    info_o.width  = width;
    // adding the lowest set bit clears a single run completely
    info_o.contig = (mask_i != '0) && ((upper & mask_i) == '0);
  end

endmodule

[rtl/bpr_chan.sv]
module bpr_chan #(
  parameter int unsigned MAX_CHANNEL_BITS = bpr_pkg::MAX_CHANNEL_BITS_DEF
) (
  input  logic                       clk,
  input  bpr_pkg::pipe_ctl_t         ctl,
  input  logic [bpr_pkg::MASK_W-1:0] word_i,
  input  logic [bpr_pkg::MASK_W-1:0] mask_i,
  input  bpr_pkg::mask_info_t        info_i,
  output logic [bpr_pkg::COMP_W-1:0] comp_o
);
  import bpr_pkg::*;

  // extract
  logic [MASK_W-1:0]           field;
  logic [MAX_CHANNEL_BITS-1:0] v_r;
  logic [WIDTH_W-1:0]          wd_r;

  // prep: truncate wide fields, form v*255 + max/2 for narrow ones
  logic                 byp_nxt, byp2_r, byp3_r;
  logic [COMP_W-1:0]    res_nxt, res2_r, res3_r;
  logic [X_W-1:0]       x_nxt, x2_r, x3_r;
  logic [LOWW_W-1:0]    wlo2_r, wlo3_r;
  logic [NARROW_W-1:0]  top2;
  logic [MAX_CHANNEL_BITS-1:0] v_shr;

  // multiply by reciprocal
  logic [X_W+RECIP_W-1:0] prod_full;
  logic [PROD_W-1:0]    p_r;

  // correct and select
  logic [COMP_W-1:0]    q0;
  logic [X_W-1:0]       qtop;
  logic [X_W-1:0]       rem;
  logic [NARROW_W-1:0]  top3;
  logic [COMP_W-1:0]    comp_nxt, comp_r;

  assign field = (word_i & mask_i) >> info_i.shift;

  always_ff @(posedge clk) begin
    if (ctl.load[STG_EXTRACT]) begin
      v_r  <= field[MAX_CHANNEL_BITS-1:0];
      wd_r <= info_i.width;
    end
  end

  always_comb begin
    top2    = field_max(wd_r[LOWW_W-1:0]);
    v_shr   = v_r >> (wd_r - WIDTH_W'(COMP_W));
    byp_nxt = (wd_r >= WIDTH_W'(COMP_W));
    res_nxt = v_shr[COMP_W-1:0];
    x_nxt   = X_W'({v_r[NARROW_W-1:0], 8'h00}) - X_W'(v_r[NARROW_W-1:0])
            + X_W'(top2 >> 1);
  end

  always_ff @(posedge clk) begin
    if (ctl.load[STG_PREP]) begin
      byp2_r <= byp_nxt;
      res2_r <= res_nxt;
      x2_r   <= x_nxt;
      wlo2_r <= wd_r[LOWW_W-1:0];
    end
  end

  assign prod_full = (X_W+RECIP_W)'(x2_r) * (X_W+RECIP_W)'(recip_of(wlo2_r));

  always_ff @(posedge clk) begin
    if (ctl.load[STG_MUL]) begin
      p_r    <= prod_full[PROD_W-1:0];
      byp3_r <= byp2_r;
      res3_r <= res2_r;
      x3_r   <= x2_r;
      wlo3_r <= wlo2_r;
    end
  end

  always_comb begin
    q0   = p_r[PROD_W-1:RECIP_FRAC];
    top3 = field_max(wlo3_r);
    qtop = (X_W'(q0) << wlo3_r) - X_W'(q0);
    rem  = x3_r - qtop;
    if (byp3_r) begin
      comp_nxt = res3_r;
    end else if (rem >= X_W'(top3)) begin
      comp_nxt = q0 + COMP_W'(1);
    end else begin
      comp_nxt = q0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load[STG_OUT]) begin
      comp_r <= comp_nxt;
    end
  end

  assign comp_o = comp_r;

endmodule

[rtl/bpr_pipe_ctl.sv]
module bpr_pipe_ctl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               out_ready,
  output bpr_pkg::pipe_ctl_t ctl,
  output logic               out_valid
);
  import bpr_pkg::*;

  logic [NUM_STAGES-1:0] vld_r, vld_nxt;

  // a stage loads when it is empty or its content moves on
  always_comb begin
    ctl.load[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      ctl.load[i] = !vld_r[i] || ctl.load[i+1];
    end
    vld_nxt[0] = ctl.load[0] ? in_valid : vld_r[0];
    for (int i = 1; i < NUM_STAGES; i++) begin
      vld_nxt[i] = ctl.load[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign out_valid = vld_r[NUM_STAGES-1];

endmodule

[rtl/bitfield_pixel_to_rgb888.sv]
// Unpacks one bitfield-coded pixel word per clock into 8-bit red, green and
// blue. Each channel is located by its configured mask; 8-bit fields pass
// through, wider fields keep their top 8 bits and narrower fields are scaled
// to full range with rounding. Pixels pass through the mask layout, field
// extract, prep, reciprocal multiply and correct/output pipeline stages;
// one pixel is taken every clock while the output side keeps up, and
// in_tready falls only when the output register is full and stalled. When
// any mask is zero, not a single run, wider than MAX_CHANNEL_BITS, overlaps
// another, or reaches above bit 23 with pixel_bytes other than 4,
// out_tuser (mask_error) is set and the components read zero. Write
// registers only while no pixel is in flight.
module bitfield_pixel_to_rgb888 #(
  parameter int unsigned MAX_CHANNEL_BITS = bpr_pkg::MAX_CHANNEL_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: pixel_word[31:0]
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [31:0]                   in_tdata,
  // out_tdata: red[7:0], green[15:8], blue[23:16]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [23:0]                   out_tdata,
  // out_tuser: mask_error[0]
  output logic                          out_tuser,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bpr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import bpr_pkg::*;

  localparam int unsigned NCH = 3;

  logic [MASK_W-1:0] mask_r [NCH];
  logic [PIXB_W-1:0] pixb_r;

  pipe_ctl_t  ctl;
  mask_info_t info [NCH];
  mask_info_t info_r [NCH];
  logic [MASK_W-1:0] word_nxt, word_r;
  logic       four;
  logic       hi_bad, overlap, chan_bad;
  logic       err_nxt;
  logic [NUM_STAGES-1:0] err_r;
  logic [COMP_W-1:0] comp [NCH];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r[0] <= MASK_RED_RST;
      mask_r[1] <= MASK_GREEN_RST;
      mask_r[2] <= MASK_BLUE_RST;
      pixb_r    <= PIXB_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MASK_RED:    mask_r[0] <= cfg_data;
        CFG_MASK_GREEN:  mask_r[1] <= cfg_data;
        CFG_MASK_BLUE:   mask_r[2] <= cfg_data;
        CFG_PIXEL_BYTES: pixb_r    <= cfg_data[PIXB_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar c = 0; c < NCH; c++) begin : g_info
    bpr_mask_info u_info (
      .mask_i (mask_r[c]),
      .info_o (info[c])
    );
  end

  always_comb begin
    four     = (pixb_r == PIXB_FOUR);
    word_nxt = four ? in_tdata : {8'h00, in_tdata[23:0]};
    hi_bad   = !four && ((mask_r[0] | mask_r[1] | mask_r[2]) >> 24) != '0;
    overlap  = ((mask_r[0] & mask_r[1]) | (mask_r[0] & mask_r[2]) |
                (mask_r[1] & mask_r[2])) != '0;
    chan_bad = 1'b0;
    for (int c = 0; c < NCH; c++) begin
      if (!info[c].contig || 32'(info[c].width) > MAX_CHANNEL_BITS) chan_bad = 1'b1;
    end
    err_nxt = hi_bad || overlap || chan_bad;
  end

  always_ff @(posedge clk) begin
    if (ctl.load[STG_LAYOUT]) begin
      word_r   <= word_nxt;
      info_r   <= info;
      err_r[0] <= err_nxt;
    end
    for (int i = 1; i < NUM_STAGES; i++) begin
      if (ctl.load[i]) err_r[i] <= err_r[i-1];
    end
  end

  bpr_pipe_ctl u_ctl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .out_ready (out_tready),
    .ctl       (ctl),
    .out_valid (out_tvalid)
  );

  assign in_tready = ctl.load[STG_LAYOUT];

  for (genvar c = 0; c < NCH; c++) begin : g_chan
    bpr_chan #(
      .MAX_CHANNEL_BITS (MAX_CHANNEL_BITS)
    ) u_chan (
      .clk    (clk),
      .ctl    (ctl),
      .word_i (word_r),
      .mask_i (mask_r[c]),
      .info_i (info_r[c]),
      .comp_o (comp[c])
    );
  end

  assign out_tuser = err_r[STG_OUT];
  assign out_tdata = err_r[STG_OUT] ? '0 : {comp[2], comp[1], comp[0]};

endmodule
